/* sv/grid_nearest_cell_locator_unit_assert.svh */
// Assertion macros shared by the checker of the grid nearest cell locator.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef GRID_NEAREST_CELL_LOCATOR_UNIT_ASSERT_SVH
`define GRID_NEAREST_CELL_LOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GNC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grid locator check failed");

// Consequent must hold in the cycle after the antecedent.
`define GNC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grid locator check failed");

`endif

/* sv/gnc_pkg.sv */
// Shared types and constants of the grid nearest cell locator.
// No dependencies; the sequencer, compare unit, top level, checker and testbench import it.
package gnc_pkg;

	localparam int MAX_COLUMNS = 1024;
	localparam int MAX_ROWS    = 1024;
	localparam int MAX_DEPTH   = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;

	localparam int COL_AW = $clog2(MAX_COLUMNS);
	localparam int ROW_AW = $clog2(MAX_ROWS);

	localparam int CFG_W  = 11;
	localparam int IDX_W  = $clog2(MAX_DEPTH + 1);
	localparam int CNT_W  = (IDX_W > CFG_W) ? IDX_W : CFG_W;
	localparam int PROD_W = 2 * CNT_W;

	localparam int COORD_W = 32;
	localparam int OP_W    = COORD_W + 2;
	localparam int CELL_W  = 20;
	localparam int ENTRY_W = 10;

	localparam logic [CFG_W-1:0] COUNT_RESET = CFG_W'(1024);

	localparam logic [1:0] KIND_WR_LON = 2'd0;
	localparam logic [1:0] KIND_WR_LAT = 2'd1;
	localparam logic [1:0] KIND_QUERY  = 2'd2;

	localparam logic REG_COLUMNS = 1'b0;
	localparam logic REG_ROWS    = 1'b1;

	typedef struct packed {
		logic signed [OP_W-1:0] a;
		logic signed [OP_W-1:0] b0;
		logic signed [OP_W-1:0] b1;
	} alu_req_t;

endpackage

/* sv/gnc_ram.sv */
// Simple dual-port table memory with one write port and one registered read port.
// Generic; depends on nothing.
module gnc_ram #(
	parameter int AW = 10,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/gnc_alu.sv */
// Shared compare unit of the locator: tests a against the sum b0 + b1.
// Depends on gnc_pkg.
module gnc_alu (
	input  gnc_pkg::alu_req_t req,
	output logic              lt
);
	import gnc_pkg::*;

	logic signed [OP_W-1:0] sum;

	assign sum = req.b0 + req.b1;
	assign lt  = req.a < sum;

endmodule

/* sv/gnc_seq.sv */
// Query sequencer: walks the longitude table, then the latitude table, one entry per
// cycle through the shared compare unit, and forms the row-major cell index.
// Depends on gnc_pkg and the compare unit instantiated at the top level.
module gnc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  kind,
	input  logic signed [31:0]          lon_value,
	input  logic signed [31:0]          lat_value,
	input  logic [gnc_pkg::CNT_W-1:0]   cols,
	input  logic [gnc_pkg::CNT_W-1:0]   rows,
	input  logic [gnc_pkg::COORD_W-1:0] rd_lon,
	input  logic [gnc_pkg::COORD_W-1:0] rd_lat,
	output logic [gnc_pkg::CNT_W-1:0]   rd_addr,
	output gnc_pkg::alu_req_t           alu_req,
	input  logic                        alu_lt,
	output logic                        busy,
	output logic                        done,
	output logic                        found,
	output logic [gnc_pkg::CELL_W-1:0]  cell_index
);
	import gnc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_PICK, ST_MUL} state_t;

	state_t                     state_q;
	logic                       axis_q;
	logic [CNT_W-1:0]           k_q;
	logic signed [COORD_W-1:0]  lon_q;
	logic signed [COORD_W-1:0]  lat_q;
	logic signed [COORD_W-1:0]  prev_q;
	logic signed [COORD_W-1:0]  cur_q;
	logic [CNT_W-1:0]           ci_q;
	logic [CNT_W-1:0]           ri_q;
	logic                       done_q;
	logic                       found_q;
	logic [CELL_W-1:0]          cell_q;

	logic signed [COORD_W-1:0]  coord;
	logic signed [COORD_W-1:0]  tab;
	logic [CNT_W-1:0]           used;
	logic [CNT_W-1:0]           pick_pos;
	logic [PROD_W-1:0]          prod;

	assign coord = axis_q ? lat_q : lon_q;
	assign tab   = axis_q ? rd_lat : rd_lon;
	assign used  = axis_q ? rows : cols;

	always_comb begin
		if (state_q == ST_PICK) begin
			alu_req.a  = {coord[COORD_W-1], coord, 1'b0};
			alu_req.b0 = {{2{prev_q[COORD_W-1]}}, prev_q};
			alu_req.b1 = {{2{cur_q[COORD_W-1]}}, cur_q};
		end else begin
			alu_req.a  = {{2{tab[COORD_W-1]}}, tab};
			alu_req.b0 = {{2{coord[COORD_W-1]}}, coord};
			alu_req.b1 = '0;
		end
	end

	assign rd_addr  = (state_q == ST_WALK) ? k_q + CNT_W'(1) : '0;
	assign pick_pos = ((k_q != '0) && alu_lt) ? k_q - CNT_W'(1) : k_q;
	assign prod     = PROD_W'(ri_q) * PROD_W'(cols);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			cell_q  <= '0;
			axis_q  <= 1'b0;
			k_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start && (kind == KIND_QUERY)) begin
						lon_q   <= lon_value;
						lat_q   <= lat_value;
						axis_q  <= 1'b0;
						k_q     <= '0;
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (k_q >= used) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						cell_q  <= '0;
						state_q <= ST_IDLE;
					end else if (alu_lt) begin
						prev_q <= tab;
						k_q    <= k_q + CNT_W'(1);
					end else begin
						if (k_q == '0) begin
							prev_q <= tab;
						end
						cur_q   <= tab;
						state_q <= ST_PICK;
					end
				end
				ST_PICK: begin
					if ((k_q == '0) && alu_lt) begin
						done_q  <= 1'b1;
						found_q <= 1'b0;
						cell_q  <= '0;
						state_q <= ST_IDLE;
					end else if (!axis_q) begin
						ci_q    <= pick_pos;
						axis_q  <= 1'b1;
						k_q     <= '0;
						state_q <= ST_WALK;
					end else begin
						ri_q    <= pick_pos;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					done_q  <= 1'b1;
					found_q <= 1'b1;
					cell_q  <= CELL_W'(prod + PROD_W'(ci_q));
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign found      = found_q;
	assign cell_index = cell_q;

endmodule

/* sv/grid_nearest_cell_locator_unit.sv */
// Channel   | Handshake            | Payload
// input     | start, busy          | kind, entry_index, lon_value, lat_value
// result    | done (one cycle)     | found, cell_index
// config    | psel, penable, pwrite| paddr, pwdata, prdata, pready
// A write item leaves busy low. A query item stays busy while it walks the longitude
// table, then the latitude table, with a pick step per axis and a multiply step. The
// result strobe follows in the next cycle, as busy falls. The walk is set by the single
// read port of each table. Reset is asynchronous and needs no clearing pass; the result
// strobe cannot be stalled by the receiver.
module grid_nearest_cell_locator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                start,
	output logic                busy,
	input  logic [1:0]          kind,
	input  logic [9:0]          entry_index,
	input  logic signed [31:0]  lon_value,
	input  logic signed [31:0]  lat_value,
	output logic                done,
	output logic                found,
	output logic [19:0]         cell_index
);
	import gnc_pkg::*;

	logic [CFG_W-1:0]   columns_q;
	logic [CFG_W-1:0]   rows_q;
	logic               cfg_wr;
	logic [CNT_W-1:0]   cols_eff;
	logic [CNT_W-1:0]   rows_eff;
	logic               accept;
	logic               we_lon;
	logic               we_lat;
	logic [CNT_W-1:0]   rd_addr;
	logic [COORD_W-1:0] rd_lon;
	logic [COORD_W-1:0] rd_lat;
	alu_req_t           alu_req;
	logic               alu_lt;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COUNT_RESET;
			rows_q    <= COUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_COLUMNS: columns_q <= pwdata[CFG_W-1:0];
				REG_ROWS:    rows_q    <= pwdata[CFG_W-1:0];
				default:     columns_q <= columns_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COLUMNS: prdata = 32'(columns_q);
			REG_ROWS:    prdata = 32'(rows_q);
			default:     prdata = '0;
		endcase
	end

	assign cols_eff = (CNT_W'(columns_q) > CNT_W'(MAX_COLUMNS)) ?
		CNT_W'(MAX_COLUMNS) : CNT_W'(columns_q);
	assign rows_eff = (CNT_W'(rows_q) > CNT_W'(MAX_ROWS)) ?
		CNT_W'(MAX_ROWS) : CNT_W'(rows_q);

	assign accept = start && !busy;
	assign we_lon = accept && (kind == KIND_WR_LON) && (32'(entry_index) < MAX_COLUMNS);
	assign we_lat = accept && (kind == KIND_WR_LAT) && (32'(entry_index) < MAX_ROWS);

	gnc_ram #(.AW(COL_AW), .DW(COORD_W)) u_lon_ram (
		.clk   (clk),
		.we    (we_lon),
		.waddr (COL_AW'(entry_index)),
		.wdata (lon_value),
		.raddr (rd_addr[COL_AW-1:0]),
		.rdata (rd_lon)
	);

	gnc_ram #(.AW(ROW_AW), .DW(COORD_W)) u_lat_ram (
		.clk   (clk),
		.we    (we_lat),
		.waddr (ROW_AW'(entry_index)),
		.wdata (lat_value),
		.raddr (rd_addr[ROW_AW-1:0]),
		.rdata (rd_lat)
	);

	gnc_alu u_alu (
		.req (alu_req),
		.lt  (alu_lt)
	);

	gnc_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (accept),
		.kind       (kind),
		.lon_value  (lon_value),
		.lat_value  (lat_value),
		.cols       (cols_eff),
		.rows       (rows_eff),
		.rd_lon     (rd_lon),
		.rd_lat     (rd_lat),
		.rd_addr    (rd_addr),
		.alu_req    (alu_req),
		.alu_lt     (alu_lt),
		.busy       (busy),
		.done       (done),
		.found      (found),
		.cell_index (cell_index)
	);

endmodule

/* sv/gnc_checker.sv */
// Port-level checker of the grid nearest cell locator, bound to the top level.
// Depends on gnc_pkg and the assertion macro header.
`include "grid_nearest_cell_locator_unit_assert.svh"

module gnc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [1:0]  kind,
	input logic        done,
	input logic        found,
	input logic [19:0] cell_index
);
	import gnc_pkg::*;

	`GNC_ASSERT_NEXT(a_query_goes_busy, start && !busy && (kind == KIND_QUERY), busy)
	`GNC_ASSERT_NOW(a_done_when_idle, done, !busy)
	`GNC_ASSERT_NOW(a_miss_has_zero_index, done && !found, cell_index == '0)
	`GNC_ASSERT_NEXT(a_done_single_cycle, done, !done)

endmodule

bind grid_nearest_cell_locator_unit gnc_checker u_gnc_checker (.*);

/* bench/tb_grid_nearest_cell_locator_unit.sv */
// Self-checking testbench for grid_nearest_cell_locator_unit: a directed script, then
// phases of random table loads and point queries under several grid sizes.
// Depends on gnc_pkg and the unit itself; each result is checked against the script or a predictor.
module tb_grid_nearest_cell_locator_unit;
	import gnc_pkg::*;

	localparam logic [1:0] KIND_RESERVED = 2'd3;
	localparam int RUN_LIMIT    = 3_000_000;
	localparam int DRAIN_CYCLES = 2100;
	localparam int PHASES       = 9;
	localparam int LOAD_CAP     = 8;

	typedef struct packed {
		logic              found;
		logic [CELL_W-1:0] cell_idx;
	} cell_answer_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [ENTRY_W-1:0] idx;
		logic [COORD_W-1:0] lon;
		logic [COORD_W-1:0] lat;
		logic               typed;
		logic               want_found;
		logic [CELL_W-1:0]  want_cell;
	} script_row_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [2:0]          paddr;
	logic [31:0]         pwdata;
	logic [31:0]         prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic [1:0]          kind;
	logic [9:0]          entry_index;
	logic signed [31:0]  lon_value;
	logic signed [31:0]  lat_value;
	logic                done;
	logic                found;
	logic [19:0]         cell_index;

	int lon_tab [MAX_COLUMNS];
	int lat_tab [MAX_ROWS];
	logic [CFG_W-1:0] col_count = COUNT_RESET;
	logic [CFG_W-1:0] row_count = COUNT_RESET;
	cell_answer_t pending_cells[$];
	script_row_t script[$];
	int fail_count = 0;
	int cycle_count = 0;
	bit steady = 1'b0;

	grid_nearest_cell_locator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.kind(kind),
		.entry_index(entry_index),
		.lon_value(lon_value),
		.lat_value(lat_value),
		.done(done),
		.found(found),
		.cell_index(cell_index)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		cell_answer_t want;
		if (arst_n && done) begin
			if (pending_cells.size() == 0) begin
				$error("result with no query waiting: found %0b, cell_index %0d", found, cell_index);
				fail_count++;
			end else begin
				want = pending_cells.pop_front();
				if (found !== want.found) begin
					$error("found mismatch: expected %0b, actual %0b", want.found, found);
					fail_count++;
				end
				if (cell_index !== want.cell_idx) begin
					$error("cell_index mismatch: expected %0d, actual %0d", want.cell_idx,
						cell_index);
					fail_count++;
				end
			end
		end
	end

	function automatic int tab_at(input bit on_lon, input int k);
		return on_lon ? lon_tab[k] : lat_tab[k];
	endfunction

	function automatic int axis_entries(input logic [CFG_W-1:0] cnt, input int depth);
		return (cnt == 0) ? 1 : ((cnt > depth) ? depth : int'(cnt));
	endfunction

	function automatic bit nearest_on_axis(input bit on_lon, input int used, input int coord,
		output int pos);
		longint c;
		longint here;
		longint prior;
		longint dist_prior;
		int k;
		pos = 0;
		c = coord;
		if (c < longint'(tab_at(on_lon, 0))) return 1'b0;
		for (k = 0; k < used; k++) begin
			here = tab_at(on_lon, k);
			if (here >= c) begin
				prior = tab_at(on_lon, (k > 0) ? k - 1 : 0);
				dist_prior = (c > prior) ? c - prior : prior - c;
				pos = (dist_prior < here - c) ? k - 1 : k;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void account_item(input logic [1:0] k, input logic [ENTRY_W-1:0] ix,
		input logic [31:0] lo, input logic [31:0] la);
		int cols_eff;
		int rows_eff;
		int ci;
		int ri;
		cell_answer_t ans;
		case (k)
			KIND_WR_LON: lon_tab[ix] = lo;
			KIND_WR_LAT: lat_tab[ix] = la;
			KIND_QUERY: begin
				cols_eff = (col_count > MAX_COLUMNS) ? MAX_COLUMNS : int'(col_count);
				rows_eff = (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
				ans = '0;
				if (nearest_on_axis(1'b1, cols_eff, lo, ci) &&
					nearest_on_axis(1'b0, rows_eff, la, ri)) begin
					ans.found = 1'b1;
					ans.cell_idx = CELL_W'(ri * cols_eff + ci);
				end
				pending_cells.push_back(ans);
			end
			default: ;
		endcase
	endfunction

	function automatic int sender_gap();
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int pick_coord(input bit on_lon, input int n);
		int k;
		longint mid;
		k = $urandom_range(0, n - 1);
		case ($urandom_range(0, 5))
			0: return tab_at(on_lon, k);
			1: return tab_at(on_lon, k) + $urandom_range(0, 6) - 3;
			2: begin
				if (k + 1 < n) begin
					mid = (longint'(tab_at(on_lon, k)) + longint'(tab_at(on_lon, k + 1))) >>> 1;
					return int'(mid);
				end
				return tab_at(on_lon, k);
			end
			3: return tab_at(on_lon, 0) - $urandom_range(1, 1000);
			4: return tab_at(on_lon, n - 1) + $urandom_range(1, 1000);
			default: return $urandom();
		endcase
	endfunction

	task automatic send_item(input logic [1:0] k, input logic [ENTRY_W-1:0] ix,
		input logic [31:0] lo, input logic [31:0] la, input bit typed,
		input cell_answer_t typed_ans);
		kind = k;
		entry_index = ix;
		lon_value = lo;
		lat_value = la;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
		if (typed) pending_cells.push_back(typed_ans);
		else account_item(k, ix, lo, la);
	endtask

	task automatic pause_sender(input int gap);
		if (gap > 0) begin
			start = 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain_results();
		start = 1'b0;
		while (pending_cells.size() != 0) @(negedge clk);
	endtask

	task automatic write_count_register(input logic reg_sel, input logic [CFG_W-1:0] value);
		logic [31:0] noise;
		logic [31:0] readback;
		noise = $urandom();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {reg_sel, 2'b00};
		pwdata = {noise[31:CFG_W], value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		if (reg_sel == REG_COLUMNS) col_count = value;
		else row_count = value;
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (readback[CFG_W-1:0] !== value) begin
			$error("count register mismatch: expected %0d, actual %0d", value,
				readback[CFG_W-1:0]);
			fail_count++;
		end
	endtask

	// Loads entries 0..n-1 of one axis with a non-decreasing sequence that fits in 32 bits.
	// When more entries are in use than are loaded, the last one holds the largest
	// coordinate so that no walk runs past it.
	task automatic load_axis(input bit on_lon, input int n, input bit cut);
		int cur;
		int span;
		int stride;
		int k;
		int val;
		span = 32'h7FFF_FFFF / n;
		if ($urandom_range(0, 7) == 0) cur = 32'h8000_0000;
		else cur = -int'($urandom_range(1, 32'h7FFF_FFFF));
		for (k = 0; k < n; k++) begin
			val = (cut && (k == n - 1)) ? 32'h7FFF_FFFF : cur;
			send_item(on_lon ? KIND_WR_LON : KIND_WR_LAT, ENTRY_W'(k),
				on_lon ? val : $urandom(), on_lon ? $urandom() : val, 1'b0, '0);
			pause_sender(sender_gap());
			case ($urandom_range(0, 7))
				0: stride = 0;
				1, 2: stride = $urandom_range(1, 4);
				default: stride = $urandom_range(1, span);
			endcase
			cur += stride;
		end
	endtask

	task automatic run_random_items(input int count, input int n_lon, input int n_lat,
		input bit lon_cut, input bit lat_cut);
		int r;
		int i;
		bit on_lon;
		logic [ENTRY_W-1:0] ix;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 19) == 0) drain_results();
			r = $urandom_range(0, 99);
			on_lon = $urandom_range(0, 1);
			if (r < 74) begin
				send_item(KIND_QUERY, ENTRY_W'($urandom()), pick_coord(1'b1, n_lon),
					pick_coord(1'b0, n_lat), 1'b0, '0);
			end else if (r < 80) begin
				ix = on_lon ? ENTRY_W'($urandom_range(0, n_lon - 1 - int'(lon_cut))) :
					ENTRY_W'($urandom_range(0, n_lat - 1 - int'(lat_cut)));
				send_item(on_lon ? KIND_WR_LON : KIND_WR_LAT, ix, $urandom(), $urandom(),
					1'b0, '0);
			end else if (r < 87) begin
				if (on_lon) ix = (n_lon < MAX_COLUMNS) ?
					ENTRY_W'($urandom_range(n_lon, MAX_COLUMNS - 1)) : ENTRY_W'($urandom());
				else ix = (n_lat < MAX_ROWS) ?
					ENTRY_W'($urandom_range(n_lat, MAX_ROWS - 1)) : ENTRY_W'($urandom());
				send_item(on_lon ? KIND_WR_LON : KIND_WR_LAT, ix, $urandom(), $urandom(),
					1'b0, '0);
			end else if (r < 92) begin
				send_item(KIND_RESERVED, ENTRY_W'($urandom()), $urandom(), $urandom(), 1'b0, '0);
			end else begin
				send_item(KIND_QUERY, ENTRY_W'($urandom()), $urandom(), $urandom(), 1'b0, '0);
			end
			pause_sender(sender_gap());
		end
	endtask

	// A negative size asks for a random small grid dimension.
	task automatic run_phase(input int cols_val, input int rows_val, input int count);
		logic [CFG_W-1:0] cv;
		logic [CFG_W-1:0] rv;
		int n_lon;
		int n_lat;
		bit lon_cut;
		bit lat_cut;
		drain_results();
		while (busy) @(negedge clk);
		repeat (8) @(negedge clk);
		cv = (cols_val < 0) ? CFG_W'($urandom_range(2, 16)) : CFG_W'(cols_val);
		rv = (rows_val < 0) ? CFG_W'($urandom_range(2, 16)) : CFG_W'(rows_val);
		write_count_register(REG_COLUMNS, cv);
		write_count_register(REG_ROWS, rv);
		n_lon = axis_entries(cv, MAX_COLUMNS);
		n_lat = axis_entries(rv, MAX_ROWS);
		lon_cut = (n_lon > LOAD_CAP);
		lat_cut = (n_lat > LOAD_CAP);
		if (lon_cut) n_lon = LOAD_CAP;
		if (lat_cut) n_lat = LOAD_CAP;
		load_axis(1'b1, n_lon, lon_cut);
		load_axis(1'b0, n_lat, lat_cut);
		run_random_items(count, n_lon, n_lat, lon_cut, lat_cut);
	endtask

	initial begin
		int phase_cols [PHASES];
		int phase_rows [PHASES];
		cell_answer_t typed_ans;
		int p;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		kind = KIND_WR_LON;
		entry_index = '0;
		lon_value = '0;
		lat_value = '0;
		phase_cols = '{2, 1, 0, 4, -1, 2047, -1, 3, -1};
		phase_rows = '{2, 3, 2, 1, -1, 1024, -1, 0, -1};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// The grid keeps its reset size here, so every query stays inside the first five entries.
		script.push_back('{KIND_WR_LON, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LON, 10'd1, -1000, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LON, 10'd2, 0, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LON, 10'd3, 1000, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LON, 10'd4, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'd0, 32'h5A5A_5A5A, -5000, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'd1, 32'h5A5A_5A5A, -10, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'd2, 32'h5A5A_5A5A, 10, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'd3, 32'h5A5A_5A5A, 5000, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'd4, 32'h5A5A_5A5A, 32'h7FFF_FFFF, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_WR_LAT, 10'h3FF, 32'hFFFF_FFFF, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_RESERVED, 10'h3FF, 0, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, 0, 32'h8000_0000, 1'b1, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, 32'h8000_0000, -5000, 1'b1, 1'b1, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 20'd4100});
		script.push_back('{KIND_QUERY, 10'd0, 32'h4000_0000, -5001, 1'b1, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, -500, 0, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, -700, -9, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'd0, 999, 4999, 1'b0, 1'b0, 20'd0});
		script.push_back('{KIND_QUERY, 10'h3FF, 1, 11, 1'b0, 1'b0, 20'd0});

		foreach (script[i]) begin
			typed_ans.found = script[i].want_found;
			typed_ans.cell_idx = script[i].want_cell;
			send_item(script[i].kind, script[i].idx, script[i].lon, script[i].lat,
				script[i].typed, typed_ans);
			pause_sender(sender_gap());
		end

		for (p = 0; p < PHASES; p++) begin
			steady = (p % 3 == 1);
			run_phase(phase_cols[p], phase_rows[p], (phase_cols[p] > 1024) ? 10 : 22);
		end

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
